// ===== src/differential_drive_odometry_macros.svh =====
// Assertion macros for the differential drive odometry block.
// Included by the top-level RTL file, the one that carries concurrent assertions.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define ODO_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("odometry assertion failed");
// next-cycle implication
`define ODO_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("odometry assertion failed");
`else
`define ODO_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ODO_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/odo_pkg.sv =====
// Shared types, constants and tables for the odometry block.
// No dependencies; used by all odo_* modules and the top level.
`timescale 1ns / 1ps

package odo_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ANGLE_BITS = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int ATAN_IW = $clog2(ATAN_ENTRIES);
	localparam int ROT_STEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

	localparam int MUL_W = 40;
	localparam int PROD_W = 2 * MUL_W;
	localparam int DIV_N = 72;
	localparam int DIV_D = 32;
	localparam int ROT_W = 34;

	localparam logic [31:0] PATH_DIV = 32'd512000000;
	localparam logic [31:0] ARC_DIV = 32'd256000000;
	localparam logic [39:0] TURN_PER_RAD_Q32 = 40'd683565276;
	localparam logic [33:0] GAIN_INV_Q30 = 34'd652032874;

	localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
		32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

	localparam logic [2:0] CFG_RADIUS = 3'd0;
	localparam logic [2:0] CFG_BASE = 3'd1;
	localparam logic [2:0] CFG_START_X = 3'd2;
	localparam logic [2:0] CFG_START_Y = 3'd3;
	localparam logic [2:0] CFG_START_H = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP,
		S_MUL1_GO,
		S_MUL1_WAIT,
		S_DIV1_GO,
		S_DIV1_WAIT,
		S_MUL2_GO,
		S_MUL2_WAIT,
		S_DIV2_GO,
		S_DIV2_WAIT,
		S_ROT_GO,
		S_ROT_WAIT,
		S_MUL3_GO,
		S_MUL3_WAIT,
		S_FIN1,
		S_FIN2
	} odo_state_t;

	typedef struct packed {
		logic mul_a;
		logic mul_b;
		logic div_a;
		logic div_b;
		logic rot;
	} odo_unit_t;

endpackage

// ===== src/odo_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on odo_pkg for operand widths.
`timescale 1ns / 1ps

module odo_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [odo_pkg::MUL_W-1:0]     a,
	input  logic [odo_pkg::MUL_W-1:0]     b,
	output logic                          busy,
	output logic [odo_pkg::PROD_W-1:0]    p
);

	localparam int CW = $clog2(odo_pkg::MUL_W);

	logic                          busy_q;
	logic [CW-1:0]                 cnt_q;
	logic [odo_pkg::MUL_W-1:0]     a_q;
	logic [odo_pkg::PROD_W-1:0]    p_q;
	logic [odo_pkg::MUL_W:0]       sum;

	assign sum = {1'b0, p_q[odo_pkg::PROD_W-1:odo_pkg::MUL_W]}
		+ {1'b0, (p_q[0] ? a_q : {odo_pkg::MUL_W{1'b0}})};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(odo_pkg::MUL_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= {{odo_pkg::MUL_W{1'b0}}, b};
		end else if (busy_q) begin
			p_q <= {sum, p_q[odo_pkg::MUL_W-1:1]};
		end
	end

	assign busy = busy_q;
	assign p = p_q;

endmodule

// ===== src/odo_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on odo_pkg for dividend and divisor widths.
`timescale 1ns / 1ps

module odo_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [odo_pkg::DIV_N-1:0]   n,
	input  logic [odo_pkg::DIV_D-1:0]   d,
	output logic                        busy,
	output logic [odo_pkg::DIV_N-1:0]   q
);

	localparam int CW = $clog2(odo_pkg::DIV_N);

	logic                        busy_q;
	logic [CW-1:0]               cnt_q;
	logic [odo_pkg::DIV_D-1:0]   d_q;
	logic [odo_pkg::DIV_D-1:0]   rem_q;
	logic [odo_pkg::DIV_N-1:0]   q_q;
	logic [odo_pkg::DIV_D:0]     t;
	logic [odo_pkg::DIV_D:0]     diff;
	logic                        ge;

	assign t = {rem_q, q_q[odo_pkg::DIV_N-1]};
	assign diff = t - {1'b0, d_q};
	assign ge = (t >= {1'b0, d_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(odo_pkg::DIV_N - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			d_q <= d;
			rem_q <= '0;
			q_q <= n;
		end else if (busy_q) begin
			rem_q <= ge ? diff[odo_pkg::DIV_D-1:0] : t[odo_pkg::DIV_D-1:0];
			q_q <= {q_q[odo_pkg::DIV_N-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign q = q_q;

endmodule

// ===== src/odo_cordic.sv =====
// Iterative CORDIC rotation, one micro-rotation per cycle, giving cos and sin.
// Depends on odo_pkg for the arctangent table and step count.
`timescale 1ns / 1ps

module odo_cordic (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [31:0]                       angle,
	output logic                              busy,
	output logic signed [odo_pkg::ROT_W-1:0]  cos_v,
	output logic signed [odo_pkg::ROT_W-1:0]  sin_v
);

	localparam int CW = (odo_pkg::ROT_STEPS > 1) ? $clog2(odo_pkg::ROT_STEPS) : 1;
	localparam logic [31:0] MASK = 32'hFFFF_FFFF << (32 - odo_pkg::ANGLE_BITS);

	logic                              busy_q;
	logic [CW-1:0]                     step_q;
	logic                              flip_q;
	logic signed [odo_pkg::ROT_W-1:0]  x_q;
	logic signed [odo_pkg::ROT_W-1:0]  y_q;
	logic signed [odo_pkg::ROT_W-1:0]  z_q;
	logic [31:0]                       a_m;
	logic [31:0]                       a_q1;
	logic [31:0]                       a_rot;
	logic                              flip;
	logic signed [odo_pkg::ROT_W-1:0]  xs;
	logic signed [odo_pkg::ROT_W-1:0]  ys;
	logic signed [odo_pkg::ROT_W-1:0]  at;

	assign a_m = angle & MASK;
	assign a_q1 = a_m + 32'h4000_0000;
	assign flip = a_q1[31];
	assign a_rot = flip ? (a_m + 32'h8000_0000) : a_m;
	assign xs = x_q >>> step_q;
	assign ys = y_q >>> step_q;
	assign at = $signed({2'b00, odo_pkg::ATAN_TURNS[odo_pkg::ATAN_IW'(step_q)]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == CW'(odo_pkg::ROT_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			flip_q <= flip;
			x_q <= $signed(odo_pkg::GAIN_INV_Q30);
			y_q <= '0;
			z_q <= $signed({{2{a_rot[31]}}, a_rot});
		end else if (busy_q) begin
			if (!z_q[odo_pkg::ROT_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign busy = busy_q;
	assign cos_v = flip_q ? -x_q : x_q;
	assign sin_v = flip_q ? -y_q : y_q;

endmodule

// ===== src/differential_drive_odometry.sv =====
// Differential drive odometry: an item with a positive time step passes through the
// bit-serial multipliers (three passes), the restoring dividers (two passes) and a
// 16-step CORDIC; an item whose time step is not positive goes from the prep state
// straight to the output state.
// One item is worked at a time; a finished result waits in the output
// register while the next item is taken. Start register writes load the pose at once.
// Depends on odo_pkg, odo_mul, odo_div, odo_cordic and the macros header.
`timescale 1ns / 1ps
`include "differential_drive_odometry_macros.svh"

module differential_drive_odometry (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] right_speed,
	input  logic signed [15:0] left_speed,
	input  logic [31:0]        stamp_us,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pos_x_um,
	output logic signed [31:0] pos_y_um,
	output logic signed [15:0] heading_out,
	output logic signed [23:0] path_step_um,
	output logic               updated,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int MW = odo_pkg::MUL_W;
	localparam int PW = odo_pkg::PROD_W;
	localparam int NW = odo_pkg::DIV_N;
	localparam int RW = odo_pkg::ROT_W;

	odo_pkg::odo_state_t state_q, state_d;
	odo_pkg::odo_unit_t  go, busy_u;

	logic [19:0]        radius_q, base_q;
	logic signed [31:0] pose_x_q, pose_y_q;
	logic [15:0]        head_q;
	logic [31:0]        last_q;

	logic [16:0] sum_abs_q, dif_abs_q;
	logic        sum_neg_q, dif_neg_q, ok_q;
	logic [31:0] stamp_q;
	logic [30:0] dt_q;
	logic [35:0] mag_s_q, mag_d_q;
	logic [32:0] dsm_q;
	logic [31:0] dth_q;
	logic        cneg_q, sneg_q;
	logic signed [41:0] dx_q, dy_q;
	logic [15:0] head_new_q;
	logic [23:0] path_q;

	logic               out_valid_q, upd_q;
	logic signed [31:0] ox_q, oy_q;
	logic [15:0]        oh_q;
	logic [23:0]        op_q;

	logic signed [16:0] sum_c, dif_c;
	logic [31:0]        dt_c;
	logic [36:0]        mag_s_c, mag_d_c;

	logic [MW-1:0] mul_a_a, mul_a_b, mul_b_a, mul_b_b;
	logic [PW-1:0] mul_a_p, mul_b_p;
	logic [NW-1:0] div_a_n, div_b_n, div_a_q, div_b_q;
	logic [31:0]   div_a_d, div_b_d;
	logic [31:0]   rot_angle;
	logic signed [RW-1:0] cos_v, sin_v;
	logic [RW-1:0] cos_abs, sin_abs;

	logic [32:0] ddm_c, dsm_c;
	logic [31:0] half_c, dth_c;
	logic [NW-1:0] px_s, py_s;
	logic signed [NW-1:0] rx, ry;
	logic [31:0] hsum;
	logic signed [43:0] sx, sy;
	logic signed [31:0] nx, ny;
	logic out_free;

	assign in_ready = (state_q == odo_pkg::S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free = !out_valid_q || out_ready;

	assign sum_c = {right_speed[15], right_speed} + {left_speed[15], left_speed};
	assign dif_c = {right_speed[15], right_speed} - {left_speed[15], left_speed};
	assign dt_c = stamp_us - last_q;
	assign mag_s_c = sum_abs_q * radius_q;
	assign mag_d_c = dif_abs_q * radius_q;

	// cap the scaled magnitudes at 2^32
	assign dsm_c = (div_a_q[NW-1:32] != '0) ? 33'h1_0000_0000 : {1'b0, div_a_q[31:0]};
	assign ddm_c = (div_b_q[NW-1:32] != '0) ? 33'h1_0000_0000 : {1'b0, div_b_q[31:0]};

	assign dth_c = dif_neg_q ? (32'd0 - div_b_q[31:0]) : div_b_q[31:0];
	assign half_c = dif_neg_q ? (32'd0 - div_b_q[32:1]) : div_b_q[32:1];
	assign rot_angle = {head_q, 16'h0000} + half_c;

	assign cos_abs = cos_v[RW-1] ? RW'(-cos_v) : RW'(cos_v);
	assign sin_abs = sin_v[RW-1] ? RW'(-sin_v) : RW'(sin_v);

	assign px_s = (sum_neg_q ^ cneg_q) ? (NW'(0) - mul_a_p[NW-1:0]) : mul_a_p[NW-1:0];
	assign py_s = (sum_neg_q ^ sneg_q) ? (NW'(0) - mul_b_p[NW-1:0]) : mul_b_p[NW-1:0];
	assign rx = $signed(px_s) + $signed(NW'(1) << 29);
	assign ry = $signed(py_s) + $signed(NW'(1) << 29);
	assign hsum = {head_q, 16'h0000} + dth_q + 32'h0000_8000;

	assign sx = {{12{pose_x_q[31]}}, pose_x_q} + {{2{dx_q[41]}}, dx_q};
	assign sy = {{12{pose_y_q[31]}}, pose_y_q} + {{2{dy_q[41]}}, dy_q};

	always_comb begin
		if (sx > 44'sh0_7FFF_FFFF) begin
			nx = 32'sh7FFF_FFFF;
		end else if (sx < -44'sh0_8000_0000) begin
			nx = -32'sh8000_0000;
		end else begin
			nx = sx[31:0];
		end
		if (sy > 44'sh0_7FFF_FFFF) begin
			ny = 32'sh7FFF_FFFF;
		end else if (sy < -44'sh0_8000_0000) begin
			ny = -32'sh8000_0000;
		end else begin
			ny = sy[31:0];
		end
	end

	always_comb begin
		mul_a_a = {7'd0, dsm_q};
		mul_a_b = {{(MW-RW){1'b0}}, cos_abs};
		mul_b_a = {7'd0, dsm_q};
		mul_b_b = {{(MW-RW){1'b0}}, sin_abs};
		case (state_q)
			odo_pkg::S_MUL1_GO: begin
				mul_a_a = {4'd0, mag_s_q};
				mul_a_b = {9'd0, dt_q};
				mul_b_a = {4'd0, mag_d_q};
				mul_b_b = {9'd0, dt_q};
			end
			odo_pkg::S_MUL2_GO: begin
				mul_a_a = {7'd0, ddm_c};
				mul_a_b = odo_pkg::TURN_PER_RAD_Q32;
			end
			default: begin
			end
		endcase
	end

	assign div_a_n = mul_a_p[NW-1:0];
	assign div_a_d = odo_pkg::PATH_DIV;
	assign div_b_n = (state_q == odo_pkg::S_DIV2_GO) ? mul_a_p[NW-1:0] : mul_b_p[NW-1:0];
	assign div_b_d = (state_q == odo_pkg::S_DIV2_GO) ?
		((base_q == '0) ? 32'd1 : {12'd0, base_q}) : odo_pkg::ARC_DIV;

	odo_mul u_mul_a (
		.clk(clk), .arst_n(arst_n), .start(go.mul_a), .a(mul_a_a), .b(mul_a_b),
		.busy(busy_u.mul_a), .p(mul_a_p)
	);
	odo_mul u_mul_b (
		.clk(clk), .arst_n(arst_n), .start(go.mul_b), .a(mul_b_a), .b(mul_b_b),
		.busy(busy_u.mul_b), .p(mul_b_p)
	);
	odo_div u_div_a (
		.clk(clk), .arst_n(arst_n), .start(go.div_a), .n(div_a_n), .d(div_a_d),
		.busy(busy_u.div_a), .q(div_a_q)
	);
	odo_div u_div_b (
		.clk(clk), .arst_n(arst_n), .start(go.div_b), .n(div_b_n), .d(div_b_d),
		.busy(busy_u.div_b), .q(div_b_q)
	);
	odo_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(go.rot), .angle(rot_angle),
		.busy(busy_u.rot), .cos_v(cos_v), .sin_v(sin_v)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			odo_pkg::S_IDLE: if (in_valid) state_d = odo_pkg::S_PREP;
			odo_pkg::S_PREP: state_d = ok_q ? odo_pkg::S_MUL1_GO : odo_pkg::S_FIN2;
			odo_pkg::S_MUL1_GO: state_d = odo_pkg::S_MUL1_WAIT;
			odo_pkg::S_MUL1_WAIT: begin
				if (!busy_u.mul_a && !busy_u.mul_b) state_d = odo_pkg::S_DIV1_GO;
			end
			odo_pkg::S_DIV1_GO: state_d = odo_pkg::S_DIV1_WAIT;
			odo_pkg::S_DIV1_WAIT: begin
				if (!busy_u.div_a && !busy_u.div_b) state_d = odo_pkg::S_MUL2_GO;
			end
			odo_pkg::S_MUL2_GO: state_d = odo_pkg::S_MUL2_WAIT;
			odo_pkg::S_MUL2_WAIT: if (!busy_u.mul_a) state_d = odo_pkg::S_DIV2_GO;
			odo_pkg::S_DIV2_GO: state_d = odo_pkg::S_DIV2_WAIT;
			odo_pkg::S_DIV2_WAIT: if (!busy_u.div_b) state_d = odo_pkg::S_ROT_GO;
			odo_pkg::S_ROT_GO: state_d = odo_pkg::S_ROT_WAIT;
			odo_pkg::S_ROT_WAIT: if (!busy_u.rot) state_d = odo_pkg::S_MUL3_GO;
			odo_pkg::S_MUL3_GO: state_d = odo_pkg::S_MUL3_WAIT;
			odo_pkg::S_MUL3_WAIT: begin
				if (!busy_u.mul_a && !busy_u.mul_b) state_d = odo_pkg::S_FIN1;
			end
			odo_pkg::S_FIN1: state_d = odo_pkg::S_FIN2;
			odo_pkg::S_FIN2: if (out_free) state_d = odo_pkg::S_IDLE;
			default: state_d = odo_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		go = '0;
		case (state_q)
			odo_pkg::S_MUL1_GO: begin
				go.mul_a = 1'b1;
				go.mul_b = 1'b1;
			end
			odo_pkg::S_DIV1_GO: begin
				go.div_a = 1'b1;
				go.div_b = 1'b1;
			end
			odo_pkg::S_MUL2_GO: go.mul_a = 1'b1;
			odo_pkg::S_DIV2_GO: go.div_b = 1'b1;
			odo_pkg::S_ROT_GO: go.rot = 1'b1;
			odo_pkg::S_MUL3_GO: begin
				go.mul_a = 1'b1;
				go.mul_b = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= odo_pkg::S_IDLE;
			radius_q <= 20'd30000;
			base_q <= 20'd225000;
			pose_x_q <= '0;
			pose_y_q <= '0;
			head_q <= '0;
			last_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_valid_q <= (state_q == odo_pkg::S_FIN2 && out_free)
				|| (out_valid_q && !out_ready);
			if (state_q == odo_pkg::S_FIN2 && out_free) begin
				if (ok_q) begin
					pose_x_q <= nx;
					pose_y_q <= ny;
					head_q <= head_new_q;
					last_q <= stamp_q;
				end
			end
			if (cfg_valid) begin
				case (cfg_index)
					odo_pkg::CFG_RADIUS: radius_q <= cfg_data[19:0];
					odo_pkg::CFG_BASE: base_q <= cfg_data[19:0];
					odo_pkg::CFG_START_X: pose_x_q <= cfg_data;
					odo_pkg::CFG_START_Y: pose_y_q <= cfg_data;
					odo_pkg::CFG_START_H: head_q <= cfg_data[15:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sum_abs_q <= sum_c[16] ? 17'(-sum_c) : 17'(sum_c);
			dif_abs_q <= dif_c[16] ? 17'(-dif_c) : 17'(dif_c);
			sum_neg_q <= sum_c[16];
			dif_neg_q <= dif_c[16];
			stamp_q <= stamp_us;
			dt_q <= dt_c[30:0];
			ok_q <= (dt_c != '0) && !dt_c[31];
		end
		if (state_q == odo_pkg::S_PREP) begin
			mag_s_q <= mag_s_c[35:0];
			mag_d_q <= mag_d_c[35:0];
		end
		if (state_q == odo_pkg::S_MUL2_GO) begin
			dsm_q <= dsm_c;
		end
		if (state_q == odo_pkg::S_ROT_GO) begin
			dth_q <= dth_c;
		end
		if (state_q == odo_pkg::S_MUL3_GO) begin
			cneg_q <= cos_v[RW-1];
			sneg_q <= sin_v[RW-1];
		end
		if (state_q == odo_pkg::S_FIN1) begin
			dx_q <= rx[NW-1:30];
			dy_q <= ry[NW-1:30];
			head_new_q <= hsum[31:16];
			if (dsm_q >= 33'd8388608) begin
				path_q <= sum_neg_q ? 24'h80_0000 : 24'h7F_FFFF;
			end else begin
				path_q <= sum_neg_q ? (24'd0 - dsm_q[23:0]) : dsm_q[23:0];
			end
		end
		if (state_q == odo_pkg::S_FIN2 && out_free) begin
			upd_q <= ok_q;
			ox_q <= ok_q ? nx : pose_x_q;
			oy_q <= ok_q ? ny : pose_y_q;
			oh_q <= ok_q ? head_new_q : head_q;
			op_q <= ok_q ? path_q : 24'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x_um = ox_q;
	assign pos_y_um = oy_q;
	assign heading_out = oh_q;
	assign path_step_um = op_q;
	assign updated = upd_q;

	`ODO_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`ODO_ASSERT_NXT(a_result_loaded, clk, arst_n, state_q == odo_pkg::S_FIN2 && out_free, out_valid)
	`ODO_ASSERT_IMP(a_skip_no_path, clk, arst_n, out_valid && !updated, path_step_um == 24'd0)
	`ODO_ASSERT_IMP(a_rot_in_wait, clk, arst_n, busy_u.rot, state_q == odo_pkg::S_ROT_WAIT)

endmodule

// ===== tb/differential_drive_odometry_tb.sv =====
// Self-checking testbench for differential_drive_odometry: a directed table, then random
// wheel speeds and timestamps under random stalls, checked against an in-bench pose tracker.
// Depends on odo_pkg and the differential_drive_odometry RTL.
`timescale 1ns / 1ps

module differential_drive_odometry_tb;

	localparam longint unsigned MAG_CAP = 64'd4294967296;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int PHASES = 7;
	localparam int PHASE_ITEMS = 120;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [15:0] heading;
		logic signed [23:0] path;
		logic               upd;
	} pose_rec_t;

	typedef struct packed {
		logic               is_cfg;
		logic [2:0]         idx;
		logic [31:0]        data;
		logic signed [15:0] rs;
		logic signed [15:0] ls;
		logic [31:0]        st;
		logic               typed;
		pose_rec_t          res;
	} plan_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, in_ready;
	logic signed [15:0] right_speed = 0, left_speed = 0;
	logic [31:0] stamp_us = 0;
	logic out_valid, out_ready = 0;
	logic signed [31:0] pos_x_um, pos_y_um;
	logic signed [15:0] heading_out;
	logic signed [23:0] path_step_um;
	logic updated;
	logic cfg_valid = 0, cfg_ready;
	logic [2:0] cfg_index = 0;
	logic [31:0] cfg_data = 0;

	differential_drive_odometry u_dut (.*);

	always #6 clk = ~clk;

	// tracker state
	longint unsigned radius_um = 30000, base_um = 225000;
	longint track_x = 0, track_y = 0;
	logic [15:0] track_heading = 0;
	logic [31:0] track_stamp = 0;

	pose_rec_t pending_poses[$];
	int mismatches = 0, results_seen = 0, items_sent = 0, moves_seen = 0;
	int cycles = 0;
	bit hold_req = 0;
	bit no_stall = 0;

	function automatic longint unsigned arc_mag(longint s, logic [31:0] dt,
			longint unsigned dv);
		longint unsigned mag, q;
		mag = longint'(s < 0 ? -s : s) * radius_um;
		if (mag > (MAG_CAP * dv) / dt)
			return MAG_CAP;
		q = mag * dt / dv;
		return q > MAG_CAP ? MAG_CAP : q;
	endfunction

	function automatic void heading_cs(logic [31:0] angle, output longint c, output longint s);
		logic [31:0] a;
		bit flip;
		longint x, y, z, nx;
		a = angle & (32'hFFFFFFFF << (32 - odo_pkg::ANGLE_BITS));
		flip = ((a + 32'h40000000) & 32'h80000000) != 0;
		if (flip)
			a = a + 32'h80000000;
		z = longint'(signed'(a));
		x = odo_pkg::GAIN_INV_Q30;
		y = 0;
		for (int i = 0; i < odo_pkg::ROT_STEPS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z = z - longint'(odo_pkg::ATAN_TURNS[i]);
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z = z + longint'(odo_pkg::ATAN_TURNS[i]);
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic longint sat(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic pose_rec_t advance_pose(logic signed [15:0] r, logic signed [15:0] l,
			logic [31:0] st);
		pose_rec_t p;
		logic [31:0] dt, mid, hsum;
		longint sum, dif, ds, dth, half, c, s, dx, dy;
		longint unsigned dsm, ddm, tq, bse;
		dt = st - track_stamp;
		ds = 0;
		p.upd = 0;
		if (dt != 0 && !dt[31]) begin
			sum = longint'(r) + longint'(l);
			dif = longint'(r) - longint'(l);
			dsm = arc_mag(sum, dt, odo_pkg::PATH_DIV);
			ddm = arc_mag(dif, dt, odo_pkg::ARC_DIV);
			bse = base_um != 0 ? base_um : 1;
			tq = ddm * odo_pkg::TURN_PER_RAD_Q32 / bse;
			dth = dif < 0 ? -longint'(tq) : longint'(tq);
			half = dif < 0 ? -longint'(tq >> 1) : longint'(tq >> 1);
			mid = {track_heading, 16'h0} + half[31:0];
			ds = sum < 0 ? -longint'(dsm) : longint'(dsm);
			heading_cs(mid, c, s);
			dx = (ds * c + (64'sd1 <<< 29)) >>> 30;
			dy = (ds * s + (64'sd1 <<< 29)) >>> 30;
			track_x = sat(track_x + dx, -64'sd2147483648, 64'sd2147483647);
			track_y = sat(track_y + dy, -64'sd2147483648, 64'sd2147483647);
			hsum = {track_heading, 16'h0} + dth[31:0] + 32'h8000;
			track_heading = hsum[31:16];
			track_stamp = st;
			p.upd = 1;
		end
		p.x = track_x[31:0];
		p.y = track_y[31:0];
		p.heading = track_heading;
		p.path = 24'(sat(ds, -64'sd8388608, 64'sd8388607));
		return p;
	endfunction

	task automatic send_item(logic signed [15:0] r, logic signed [15:0] l, logic [31:0] st,
			bit typed, pose_rec_t want);
		pose_rec_t p;
		in_valid <= 1;
		right_speed <= r;
		left_speed <= l;
		stamp_us <= st;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		p = advance_pose(r, l, st);
		pending_poses.push_back(typed ? want : p);
		items_sent++;
	endtask

	task automatic item_gap();
		int g;
		g = 0;
		if (!no_stall) begin
			case ($urandom_range(9))
				0, 1, 2: g = $urandom_range(1, 3);
				3: g = $urandom_range(10, 80);
				default: g = 0;
			endcase
		end
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		while (pending_poses.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
		@(posedge clk);
		case (idx)
			odo_pkg::CFG_RADIUS: radius_um = data[19:0];
			odo_pkg::CFG_BASE: base_um = data[19:0];
			odo_pkg::CFG_START_X: track_x = longint'(signed'(data));
			odo_pkg::CFG_START_Y: track_y = longint'(signed'(data));
			odo_pkg::CFG_START_H: track_heading = data[15:0];
			default: ;
		endcase
	endtask

	function automatic logic signed [15:0] pick_speed();
		case ($urandom_range(9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2, 3, 4: return 16'($urandom_range(0, 65535));
			default: return $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
		endcase
	endfunction

	function automatic logic [19:0] pick_len(logic [19:0] nominal);
		case ($urandom_range(5))
			0: return 20'd1;
			1: return 20'hFFFFF;
			2: return 20'd0;
			3: return 20'($urandom_range(0, 20'hFFFFF));
			default: return nominal;
		endcase
	endfunction

	// receiver with random stalls and one long hold-off on request
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 0;
				repeat (1500) @(posedge clk);
				hold_req = 0;
			end else if (no_stall || $urandom_range(9) < 7) begin
				out_ready <= 1;
			end else begin
				stall = ($urandom_range(9) == 0) ? $urandom_range(20, 120)
					: $urandom_range(1, 4);
				out_ready <= 0;
				repeat (stall - 1) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		pose_rec_t want, got;
		if (arst_n && out_valid && out_ready) begin
			got = '{pos_x_um, pos_y_um, heading_out, path_step_um, updated};
			results_seen++;
			if (updated)
				moves_seen++;
			if (pending_poses.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: x=%0d y=%0d h=%0d path=%0d upd=%0b",
						got.x, got.y, got.heading, got.path, got.upd);
			end else begin
				want = pending_poses.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch at result %0d: exp x=%0d y=%0d h=%0d path=%0d upd=%0b",
							results_seen, want.x, want.y, want.heading, want.path, want.upd);
						$display("  got x=%0d y=%0d h=%0d path=%0d upd=%0b",
							got.x, got.y, got.heading, got.path, got.upd);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout with %0d results pending", pending_poses.size());
			$display("differential_drive_odometry test failed");
			$finish;
		end
	end

	initial begin
		plan_row_t plan[];
		logic [31:0] st;
		logic [31:0] dt;
		pose_rec_t none;
		none = '0;
		plan = '{
			'{1'b0, 3'd0, 32'd0, 16'sd0, 16'sd0, 32'd0, 1'b1, '{32'sd0, 32'sd0, 16'sd0, 24'sd0, 1'b0}},
			'{1'b0, 3'd0, 32'd0, 16'sd256, 16'sd256, 32'd1000, 1'b0, none},
			'{1'b0, 3'd0, 32'd0, 16'sh7FFF, 16'sh7FFF, 32'd2000, 1'b0, none},
			'{1'b0, 3'd0, 32'd0, 16'sh8000, 16'sh8000, 32'd3000, 1'b0, none},
			'{1'b0, 3'd0, 32'd0, 16'sh7FFF, 16'sh8000, 32'd4000, 1'b0, none},
			'{1'b0, 3'd0, 32'd0, 16'sh8000, 16'sh7FFF, 32'd5000, 1'b0, none},
			'{1'b0, 3'd0, 32'd0, 16'sd300, 16'sd100, 32'd4000, 1'b0, none},
			'{1'b0, 3'd0, 32'd0, 16'sh7FFF, 16'sd100, 32'h80001387, 1'b0, none},
			'{1'b0, 3'd0, 32'd0, 16'sd500, 16'sd500, 32'h80001387, 1'b0, none},
			'{1'b1, odo_pkg::CFG_RADIUS, 32'd0, 16'sd0, 16'sd0, 32'd0, 1'b0, none},
			'{1'b0, 3'd0, 32'd0, 16'sd1000, 16'sd200, 32'h800013EB, 1'b0, none},
			'{1'b1, odo_pkg::CFG_RADIUS, 32'hFFFFF, 16'sd0, 16'sd0, 32'd0, 1'b0, none},
			'{1'b1, odo_pkg::CFG_BASE, 32'd0, 16'sd0, 16'sd0, 32'd0, 1'b0, none},
			'{1'b0, 3'd0, 32'd0, 16'sd200, 16'sd1000, 32'h8000144F, 1'b0, none},
			'{1'b1, odo_pkg::CFG_START_X, 32'h7FFFFFFF, 16'sd0, 16'sd0, 32'd0, 1'b0, none},
			'{1'b1, odo_pkg::CFG_START_Y, 32'h80000000, 16'sd0, 16'sd0, 32'd0, 1'b0, none},
			'{1'b1, odo_pkg::CFG_START_H, 32'h00008000, 16'sd0, 16'sd0, 32'd0, 1'b0, none},
			'{1'b0, 3'd0, 32'd0, 16'sd0, 16'sd0, 32'h8000144F, 1'b1,
				'{32'sh7FFFFFFF, 32'sh80000000, 16'sh8000, 24'sd0, 1'b0}},
			'{1'b1, odo_pkg::CFG_START_H, 32'h00000000, 16'sd0, 16'sd0, 32'd0, 1'b0, none},
			'{1'b0, 3'd0, 32'd0, 16'sh7FFF, 16'sh7FFF, 32'h80011BEF, 1'b0, none},
			'{1'b1, 3'd5, 32'hDEADBEEF, 16'sd0, 16'sd0, 32'd0, 1'b0, none},
			'{1'b1, 3'd7, 32'hFFFFFFFF, 16'sd0, 16'sd0, 32'd0, 1'b0, none},
			'{1'b1, odo_pkg::CFG_RADIUS, 32'd30000, 16'sd0, 16'sd0, 32'd0, 1'b0, none},
			'{1'b1, odo_pkg::CFG_BASE, 32'd225000, 16'sd0, 16'sd0, 32'd0, 1'b0, none},
			'{1'b0, 3'd0, 32'd0, 16'sd0, 16'sd0, 32'hFFFFFFFF, 1'b0, none}
		};
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				wait_drained();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				send_item(plan[i].rs, plan[i].ls, plan[i].st, plan[i].typed, plan[i].res);
				item_gap();
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			write_reg(odo_pkg::CFG_RADIUS, pick_len(20'd30000));
			write_reg(odo_pkg::CFG_BASE, pick_len(20'd225000));
			write_reg(odo_pkg::CFG_START_X,
				ph == 1 ? 32'h7FFFFFF0 : (ph == 2 ? 32'h80000010 : $urandom));
			write_reg(odo_pkg::CFG_START_Y,
				ph == 3 ? 32'h7FFFFFF0 : (ph == 4 ? 32'h80000010 : $urandom));
			write_reg(odo_pkg::CFG_START_H, $urandom_range(0, 65535));
			no_stall = (ph == 5);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (ph == 2 && k == 40)
					hold_req = 1;
				case ($urandom_range(19))
					0: dt = 0;
					1: dt = 32'h80000000 | $urandom;
					2: dt = $urandom;
					default: dt = $urandom_range(1, 20000);
				endcase
				st = track_stamp + dt;
				send_item(pick_speed(), pick_speed(), st, 1'b0, none);
				item_gap();
			end
		end

		in_valid <= 0;
		while (pending_poses.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		$display("covered %0d items, %0d results (%0d pose updates), %0d config phases",
			items_sent, results_seen, moves_seen, PHASES + 1);
		$display("mismatches: %0d", mismatches);
		if (mismatches == 0 && pending_poses.size() == 0)
			$display("differential_drive_odometry test passed");
		else
			$display("differential_drive_odometry test failed");
		$finish;
	end

endmodule
